// File: hw/rtl/srgb_gray_luminance_macros.svh
// Assertion macros for the sRGB grayscale luminance block.
`ifndef SRGB_GRAY_LUMINANCE_MACROS_SVH
`define SRGB_GRAY_LUMINANCE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define SGL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgl assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define SGL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgl assertion failed");
`else
`define SGL_ASSERT_IMP(lbl, ante, cons)
`define SGL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/sgl_pkg.sv
// Constants, table type and table builders for the sRGB grayscale block.
package sgl_pkg;

  localparam int LinFracBits = 16;   // default fraction bits of linear light
  localparam int LinWMax     = 25;   // widest table entry (24 fraction bits + 1)
  localparam int WorkBits    = 30;   // Q2.30 working precision of the curve
  localparam int WeightW     = 16;
  localparam int SrchStages  = 4;    // two result bits per search stage

  localparam logic [WeightW-1:0] WeightRed   = 16'd13933;
  localparam logic [WeightW-1:0] WeightGreen = 16'd46871;
  localparam logic [WeightW-1:0] WeightBlue  = 16'd4732;

  // 255 * 12.92 and 255 * 1.055, scaled to integers
  localparam longint unsigned LinDiv = 64'd16473;
  localparam longint unsigned PowDiv = 64'd269025;

  typedef logic [LinWMax-1:0] tab_t [256];

  // r^5 in Q2.30, each product truncated
  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> WorkBits;
    end
    return p;
  endfunction

  // sRGB-decoded value of v/255 in Q2.30
  function automatic longint unsigned decode_q30(int unsigned v);
    longint unsigned vv, x, x2, lo, hi, mid;
    vv = 64'(v);
    if (vv <= 64'd10) begin
      return ((64'd5 * vv) << WorkBits) / LinDiv;
    end
    x  = ((64'd1000 * vv + 64'd14025) << WorkBits) / PowDiv;
    x2 = (x * x) >> WorkBits;
    lo = 64'd0;
    hi = 64'd1 << WorkBits;
    // x^0.4 by bisection on the fifth power
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q30(mid) <= x2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return (x2 * lo) >> WorkBits;
  endfunction

  // up = 0: linear table, round half up; up = 1: thresholds, round up
  function automatic tab_t build_tab(int f, bit up);
    tab_t t;
    longint unsigned d, sh, half, ones;
    sh   = 64'(WorkBits - f);
    half = 64'd1 << (sh - 64'd1);
    ones = (64'd1 << sh) - 64'd1;
    for (int v = 0; v < 256; v++) begin
      d = decode_q30(v);
      if (up) begin
        t[v] = LinWMax'((d + ones) >> sh);
      end else begin
        t[v] = LinWMax'((d + half) >> sh);
      end
    end
    return t;
  endfunction

endpackage

// File: hw/rtl/srgb_gray_luminance.sv
// sRGB pixel to Rec.709 gray byte, seven-stage pipeline.
//
//  channel | valid      | stall      | word
//  --------+------------+------------+---------------------------
//  pixel   | pix_valid  | pix_stall  | blue, green, red (8b each)
//  result  | gray_valid | gray_stall | gray (8b)
//
// One pixel per clock sustained while gray_stall is low. Stages: table
// lookup, three weight multiplies, weighted sum, then four stages of the
// threshold search at two bits each.
// rst (synchronous) clears only the stage valid bits.
// Each stage loads when it is empty or the stage after it moves, so
// bubbles close up and a stall at the output backs up stage by stage.
`include "srgb_gray_luminance_macros.svh"

module srgb_gray_luminance
  import sgl_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = LinFracBits
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_stall,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  output logic       gray_valid,
  input  logic       gray_stall,
  output logic [7:0] gray
);

  localparam int LW     = LINEAR_FRAC_BITS + 1;  // linear value up to 1.0
  localparam int PW     = LW + WeightW;          // one weighted product
  localparam int SW     = PW + 2;                // three products summed
  localparam int NStg   = 3 + SrchStages;

  // Constant curve tables, built at elaboration
  localparam tab_t LIN_TAB = build_tab(LINEAR_FRAC_BITS, 1'b0);
  localparam tab_t THR_TAB = build_tab(LINEAR_FRAC_BITS, 1'b1);

  // stage valid bits and load enables; en[NStg+1] is the output side
  logic [NStg:1]   vld;
  logic [NStg+1:1] en;

  always_comb begin
    en[NStg+1] = !gray_stall;
    for (int i = NStg; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pix_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= pix_valid;
      end
      for (int i = 2; i <= NStg; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: linearise each channel
  logic [LW-1:0] lin_r, lin_g, lin_b;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lin_r <= LIN_TAB[red][LW-1:0];
      lin_g <= LIN_TAB[green][LW-1:0];
      lin_b <= LIN_TAB[blue][LW-1:0];
    end
  end

  // stage 2: Rec.709 weights in Q0.16
  logic [PW-1:0] prod_r, prod_g, prod_b;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod_r <= PW'(lin_r) * PW'(WeightRed);
      prod_g <= PW'(lin_g) * PW'(WeightGreen);
      prod_b <= PW'(lin_b) * PW'(WeightBlue);
    end
  end

  // stage 3: sum, back to Q1.F; weights add to one so it fits LW bits
  logic [SW-1:0] wsum;
  logic [LW-1:0] lum;

  assign wsum = SW'(prod_r) + SW'(prod_g) + SW'(prod_b);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lum <= wsum[WeightW +: LW];
    end
  end

  // stages 4..7: largest k with THR_TAB[k] <= lum, two bits a stage.
  // Thresholds rise with k, so this equals the count of those reached.
  // The last stage needs no copy of the sum.
  logic [LW-1:0] srch_lum [SrchStages-1];
  logic [7:0]    srch_g   [SrchStages];

  for (genvar s = 0; s < SrchStages; s++) begin : g_srch
    localparam int BHi = 7 - 2 * s;
    logic [LW-1:0] lum_in;
    logic [7:0]    base, c1, g1, c2, g2;

    if (s == 0) begin : g_first
      assign lum_in = lum;
      assign base   = '0;
    end else begin : g_rest
      assign lum_in = srch_lum[s-1];
      assign base   = srch_g[s-1];
    end

    always_comb begin
      c1 = base | (8'd1 << BHi);
      g1 = (lum_in >= THR_TAB[c1][LW-1:0]) ? c1 : base;
      c2 = g1 | (8'd1 << (BHi - 1));
      g2 = (lum_in >= THR_TAB[c2][LW-1:0]) ? c2 : g1;
    end

    always_ff @(posedge clk) begin
      if (en[4+s]) begin
        srch_g[s] <= g2;
      end
    end

    if (s < SrchStages - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en[4+s]) begin
          srch_lum[s] <= lum_in;
        end
      end
    end
  end

  assign gray_valid = vld[NStg];
  assign gray       = srch_g[SrchStages-1];

  // input held back only when every stage is full and the output waits
  `SGL_ASSERT_IMP(a_stall_full, pix_stall, (&vld) && gray_stall)
  // a result leaves the output only by being taken (or by reset)
  `SGL_ASSERT_IMP(a_no_drop, $fell(gray_valid), $past(!gray_stall) || $past(rst))
  // an accepted pixel always occupies the first stage next cycle
  `SGL_ASSERT_NEXT(a_enter, pix_valid && !pix_stall, vld[1])

endmodule
